### rtl/touch_slider_scroll_tracker_core_defines.svh
// Assertion macros shared by the slider scroll tracker RTL.
`ifndef TOUCH_SLIDER_SCROLL_TRACKER_CORE_DEFINES_SVH
`define TOUCH_SLIDER_SCROLL_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tsst assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tsst assertion failed");

`endif

### rtl/tsst_pkg.sv
// Shared types and constants of the slider scroll tracker.
`default_nettype none
package tsst_pkg;

	// Fixed field widths
	localparam int PAD_IDX_W = 4;
	localparam int DIFF_W    = PAD_IDX_W + 1;
	localparam int VEC_W     = 3;
	localparam int TIME_W    = 32;
	localparam int STEP_W    = 8;
	localparam int TIMEOUT_W = 16;
	localparam int CFG_IDX_W = 2;

	// Furthest pad distance that still counts as a slide
	localparam logic signed [DIFF_W-1:0] MAX_HOP = DIFF_W'(2);
	localparam logic signed [DIFF_W-1:0] MIN_HOP = -DIFF_W'(2);

	// Register reset values
	localparam logic [STEP_W-1:0]    STEP_RESET    = STEP_W'(1);
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(500);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_SCROLL      = 2'd0,
		CFG_STEP_SIZE       = 2'd1,
		CFG_RELEASE_TIMEOUT = 2'd2
	} cfg_reg_t;

endpackage
`default_nettype wire

### rtl/tsst_poll_if.sv
// Poll channel: one slider sample per transaction.
`default_nettype none
interface tsst_poll_if import tsst_pkg::*; #(
	parameter int PAD_W    = 9,
	parameter int SCROLL_W = 16
);
	logic                valid;
	logic                ready;
	logic [PAD_W-1:0]    pad_bits;
	logic [TIME_W-1:0]   now_ms;
	logic [SCROLL_W-1:0] current_scroll;

	modport source (output valid, output pad_bits, output now_ms, output current_scroll,
		input ready);
	modport sink (input valid, input pad_bits, input now_ms, input current_scroll,
		output ready);
endinterface
`default_nettype wire

### rtl/tsst_result_if.sv
// Result channel: one scroll update per transaction.
`default_nettype none
interface tsst_result_if import tsst_pkg::*; #(
	parameter int SCROLL_W = 16
);
	logic                    valid;
	logic                    ready;
	logic [SCROLL_W-1:0]     new_scroll;
	logic                    pad_valid;
	logic [PAD_IDX_W-1:0]    pad_index;
	logic signed [VEC_W-1:0] scroll_vector;
	logic                    update_screen;
	logic                    activity;

	modport source (output valid, output new_scroll, output pad_valid, output pad_index,
		output scroll_vector, output update_screen, output activity, input ready);
	modport sink (input valid, input new_scroll, input pad_valid, input pad_index,
		input scroll_vector, input update_screen, input activity, output ready);
endinterface
`default_nettype wire

### rtl/touch_slider_scroll_tracker_core.sv
// Slider scroll tracker: poll register, single-pass update logic and result register.
// Each poll transaction is captured in an input register, resolved combinationally
// by a priority encoder, a distance check, a saturating add or clamped subtract and
// a release-timeout compare, and written together with the tracking state into the
// result register. One poll is taken per cycle while the input register is free or
// can move on, and a stalled result stops new polls only once both the input and
// result registers are full. Configuration writes are taken at any edge with cfg_we
// high and should only be made while no poll is in flight.
`default_nettype none
`include "touch_slider_scroll_tracker_core_defines.svh"
module touch_slider_scroll_tracker_core import tsst_pkg::*; #(
	parameter int PAD_COUNT    = 9,
	parameter int SCROLL_WIDTH = 16,
	localparam int CFG_DATA_W  = (SCROLL_WIDTH > TIMEOUT_W) ? SCROLL_WIDTH : TIMEOUT_W
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	tsst_poll_if.sink                  poll,
	tsst_result_if.source              result
);

	localparam int SW = SCROLL_WIDTH;

	// Configuration registers
	logic [SW-1:0]        max_scroll_q;
	logic [STEP_W-1:0]    step_size_q;
	logic [TIMEOUT_W-1:0] release_timeout_q;

	// Tracking state
	logic                 tracking_q;
	logic [PAD_IDX_W-1:0] last_pad_q;
	logic [TIME_W-1:0]    last_time_q;
	logic [SW-1:0]        remembered_q;

	// Input stage
	logic                 valid_s1;
	logic [PAD_COUNT-1:0] pad_bits_s1;
	logic [TIME_W-1:0]    now_ms_s1;
	logic [SW-1:0]        scroll_s1;

	// Result register
	logic                    out_valid_q;
	logic [SW-1:0]           new_scroll_q;
	logic                    pad_valid_q;
	logic [PAD_IDX_W-1:0]    pad_index_q;
	logic signed [VEC_W-1:0] vector_q;
	logic                    update_q;

	logic advance;
	logic poll_take;

	// Combinational update
	logic                     pad_any;
	logic [PAD_IDX_W-1:0]     pad_idx;
	logic signed [DIFF_W-1:0] pad_diff;
	logic                     near;
	logic                     move_up;
	logic                     move_down;
	logic [SW:0]              sum_up;
	logic [SW-1:0]            step_ext;
	logic [TIME_W-1:0]        elapsed;
	logic                     release_now;
	logic [SW-1:0]            scroll_nx;
	logic signed [VEC_W-1:0]  vector_nx;
	logic                     update_nx;

	// Handshake: move the input stage on when the result register is free or drains
	assign advance   = !out_valid_q || result.ready;
	assign poll.ready = !valid_s1 || advance;
	assign poll_take = poll.valid && poll.ready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_scroll_q      <= '0;
			step_size_q       <= STEP_RESET;
			release_timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_MAX_SCROLL:      max_scroll_q      <= cfg_data[SW-1:0];
				CFG_STEP_SIZE:       step_size_q       <= cfg_data[STEP_W-1:0];
				CFG_RELEASE_TIMEOUT: release_timeout_q <= cfg_data[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// Lowest touched pad wins
	always_comb begin
		pad_idx = '0;
		for (int i = PAD_COUNT - 1; i >= 0; i--) begin
			if (pad_bits_s1[i]) begin
				pad_idx = PAD_IDX_W'(i);
			end
		end
	end
	assign pad_any = |pad_bits_s1;

	// Distance from the held pad and direction of the slide
	assign pad_diff  = $signed({1'b0, last_pad_q}) - $signed({1'b0, pad_idx});
	assign near      = pad_any && tracking_q && (pad_diff <= MAX_HOP) && (pad_diff >= MIN_HOP);
	assign move_up   = near && (pad_diff > 0) && (scroll_s1 < max_scroll_q);
	assign move_down = near && (pad_diff < 0) && (scroll_s1 != '0);

	assign step_ext = SW'(step_size_q);
	assign sum_up   = {1'b0, scroll_s1} + (SW + 1)'(step_size_q);
	assign elapsed  = now_ms_s1 - last_time_q;
	assign release_now = !pad_any && tracking_q && (elapsed > TIME_W'(release_timeout_q));

	// Next scroll, vector and screen update
	always_comb begin
		scroll_nx = scroll_s1;
		vector_nx = '0;
		update_nx = 1'b0;
		if (move_up) begin
			scroll_nx = (sum_up < {1'b0, max_scroll_q}) ? sum_up[SW-1:0] : max_scroll_q;
		end else if (move_down) begin
			scroll_nx = (scroll_s1 >= step_ext) ? scroll_s1 - step_ext : '0;
		end
		if (near) begin
			vector_nx = pad_diff[VEC_W-1:0];
		end
		if (release_now) begin
			update_nx = (remembered_q != scroll_s1);
		end
	end

	// Hold valid bits of the input and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (poll.ready) begin
				valid_s1 <= poll.valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Capture the poll payload
	always_ff @(posedge clk) begin
		if (poll_take) begin
			pad_bits_s1 <= poll.pad_bits;
			now_ms_s1   <= poll.now_ms;
			scroll_s1   <= poll.current_scroll;
		end
	end

	// Advance tracking state as each poll leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q   <= 1'b0;
			last_pad_q   <= '0;
			last_time_q  <= '0;
			remembered_q <= '0;
		end else if (valid_s1 && advance) begin
			if (pad_any) begin
				tracking_q  <= 1'b1;
				last_pad_q  <= pad_idx;
				last_time_q <= now_ms_s1;
				if (move_up || move_down) begin
					remembered_q <= scroll_s1;
				end
			end else if (release_now) begin
				tracking_q   <= 1'b0;
				remembered_q <= scroll_s1;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			new_scroll_q <= scroll_nx;
			pad_valid_q  <= pad_any;
			pad_index_q  <= pad_idx;
			vector_q     <= vector_nx;
			update_q     <= update_nx;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.new_scroll    = new_scroll_q;
	assign result.pad_valid     = pad_valid_q;
	assign result.pad_index     = pad_index_q;
	assign result.scroll_vector = vector_q;
	assign result.update_screen = update_q;
	assign result.activity      = pad_valid_q;

	// Checks
	`TSST_ASSERT_NEXT(a_stall_holds_state, clk, arst_n,
		valid_s1 && !advance, $stable(tracking_q) && $stable(remembered_q))
	`TSST_ASSERT_NEXT(a_stage_feeds_result, clk, arst_n,
		valid_s1 && advance, out_valid_q)
	`TSST_ASSERT_NOW(a_update_only_untouched, clk, arst_n,
		out_valid_q && update_q, !pad_valid_q && (vector_q == '0))
	`TSST_ASSERT_NOW(a_vector_needs_touch, clk, arst_n,
		out_valid_q && (vector_q != '0), pad_valid_q)

endmodule
`default_nettype wire

### tb/sv/touch_slider_scroll_tracker_core_test.sv
// Self-checking testbench for the slider scroll tracker: directed and randomised polls.
`default_nettype none
module touch_slider_scroll_tracker_core_test;
	import tsst_pkg::*;

	localparam int HOLD_CYCLES = 80;
	localparam int CYCLE_LIMIT = 200000;
	localparam int CHUNK_POLLS = 190;

	typedef struct packed {
		logic [8:0]  pads;
		logic [31:0] stamp;
		logic [15:0] scroll;
	} poll_item_t;

	typedef struct packed {
		logic [15:0]       new_scroll;
		logic              pad_valid;
		logic [3:0]        pad_index;
		logic signed [2:0] scroll_vector;
		logic              update_screen;
		logic              activity;
	} slide_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we;
	cfg_reg_t   cfg_index;
	logic [15:0] cfg_data;

	tsst_poll_if #(.PAD_W(9), .SCROLL_W(16)) poll_ch ();
	tsst_result_if #(.SCROLL_W(16)) res_ch ();

	touch_slider_scroll_tracker_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.poll      (poll_ch),
		.result    (res_ch)
	);

	// Tracker copy: configuration and gesture state
	logic [15:0] scroll_cap;
	logic [7:0]  step_lines;
	logic [15:0] idle_timeout;
	logic [3:0]  held_pad;
	logic        touch_held;
	logic [31:0] touch_stamp;
	logic [15:0] saved_scroll;

	poll_item_t    polls_to_send[$];
	slide_result_t expected_results[$];
	poll_item_t    send_item;
	slide_result_t got_res;
	slide_result_t want_res;

	int          send_idle_pct = 36;
	int          recv_idle_pct = 69;
	int          mismatches = 0;
	int          polls_queued = 0;
	int          hold_left;
	int          cycle_count = 0;
	logic        hold_req = 1'b0;
	logic        hold_seen = 1'b0;
	logic [31:0] sim_ms;
	logic [15:0] app_scroll;

	// Clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Work out the result of one poll and advance the tracker copy
	function automatic slide_result_t track_poll(input poll_item_t p);
		slide_result_t r;
		logic [16:0]   sum;
		logic [15:0]   scroll;
		logic [3:0]    pad;
		logic [3:0]    pad_gap;
		logic [31:0]   elapsed;
		logic          touched;
		r = '0;
		scroll = p.scroll;
		touched = 1'b0;
		pad = '0;
		for (int i = 8; i >= 0; i--) begin
			if (p.pads[i]) begin
				touched = 1'b1;
				pad = 4'(i);
			end
		end
		if (touched) begin
			if (touch_held) begin
				pad_gap = (pad > held_pad) ? pad - held_pad : held_pad - pad;
				if (pad_gap <= 4'd2) begin
					if (pad < held_pad && scroll < scroll_cap) begin
						sum = scroll + step_lines;
						saved_scroll = scroll;
						scroll = (sum < scroll_cap) ? sum[15:0] : scroll_cap;
					end else if (pad > held_pad && scroll != 16'd0) begin
						saved_scroll = scroll;
						scroll = (scroll >= step_lines) ? scroll - step_lines : 16'd0;
					end
					if (pad_gap != 4'd0)
						r.scroll_vector = 3'(held_pad - pad);
				end
			end
			held_pad = pad;
			touch_held = 1'b1;
			touch_stamp = p.stamp;
		end else begin
			elapsed = p.stamp - touch_stamp;
			if (touch_held && elapsed > {16'd0, idle_timeout}) begin
				touch_held = 1'b0;
				r.update_screen = (saved_scroll != scroll);
				saved_scroll = scroll;
			end
		end
		r.new_scroll = scroll;
		r.pad_valid = touched;
		r.pad_index = pad;
		r.activity = touched;
		return r;
	endfunction

	// Poll sender: predict on each accepted transaction, then offer the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_ch.valid <= 1'b0;
		end else begin
			if (poll_ch.valid && poll_ch.ready)
				expected_results.push_back(track_poll({poll_ch.pad_bits, poll_ch.now_ms,
					poll_ch.current_scroll}));
			if (!poll_ch.valid || poll_ch.ready) begin
				if (polls_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					send_item = polls_to_send.pop_front();
					poll_ch.valid <= 1'b1;
					poll_ch.pad_bits <= send_item.pads;
					poll_ch.now_ms <= send_item.stamp;
					poll_ch.current_scroll <= send_item.scroll;
				end else begin
					poll_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: check each accepted transaction, stall at random or for a long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got_res = {res_ch.new_scroll, res_ch.pad_valid, res_ch.pad_index,
					res_ch.scroll_vector, res_ch.update_screen, res_ch.activity};
				if (expected_results.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: scroll=%0d pad=%0d vec=%0d",
							got_res.new_scroll, got_res.pad_index, got_res.scroll_vector);
					mismatches++;
				end else begin
					want_res = expected_results.pop_front();
					if (got_res.new_scroll !== want_res.new_scroll
							|| got_res.pad_valid !== want_res.pad_valid
							|| got_res.pad_index !== want_res.pad_index
							|| got_res.scroll_vector !== want_res.scroll_vector
							|| got_res.update_screen !== want_res.update_screen
							|| got_res.activity !== want_res.activity) begin
						if (mismatches < 10)
							$display({"mismatch: expected scroll=%0d valid=%0b pad=%0d vec=%0d ",
								"upd=%0b act=%0b, got scroll=%0d valid=%0b pad=%0d vec=%0d ",
								"upd=%0b act=%0b"},
								want_res.new_scroll, want_res.pad_valid, want_res.pad_index,
								want_res.scroll_vector, want_res.update_screen,
								want_res.activity, got_res.new_scroll, got_res.pad_valid,
								got_res.pad_index, got_res.scroll_vector,
								got_res.update_screen, got_res.activity);
						mismatches++;
					end
				end
			end
			if (hold_left != 0) begin
				res_ch.ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_req != hold_seen) begin
				res_ch.ready <= 1'b0;
				hold_seen <= hold_req;
				hold_left <= HOLD_CYCLES;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** touch_slider_scroll_tracker_core: FAILED **");
			$finish;
		end
	end

	task push_poll(input logic [8:0] pads, input logic [31:0] stamp, input logic [15:0] scroll);
		polls_to_send.push_back({pads, stamp, scroll});
		polls_queued++;
	endtask

	// Hold until every poll has gone out and every result has come back
	task wait_idle();
		do
			@(negedge clk);
		while (polls_to_send.size() != 0 || poll_ch.valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task write_reg(input cfg_reg_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_MAX_SCROLL:      scroll_cap = val;
			CFG_STEP_SIZE:       step_lines = val[7:0];
			CFG_RELEASE_TIMEOUT: idle_timeout = val;
			default: ;
		endcase
	endtask

	task apply_settings(input logic [15:0] cap, input logic [7:0] step, input logic [15:0] tmo);
		wait_idle();
		write_reg(CFG_MAX_SCROLL, cap);
		write_reg(CFG_STEP_SIZE, {8'd0, step});
		write_reg(CFG_RELEASE_TIMEOUT, tmo);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Scroll values near the cap, at the limits and at random
	function logic [15:0] pick_scroll();
		case ($urandom_range(0, 5))
			0:       return 16'd0;
			1:       return scroll_cap;
			2:       return scroll_cap - 16'd1;
			3:       return scroll_cap + 16'($urandom_range(1, 3));
			4:       return 16'($urandom);
			default: return 16'($urandom_range(0, 2 * step_lines + 1));
		endcase
	endfunction

	// One finger slide: short hops with idle polls inside the timeout, then usually a release
	task slide_gesture();
		int         pad;
		int         hops;
		logic [8:0] bits;
		pad = $urandom_range(0, 8);
		hops = $urandom_range(2, 10);
		if ($urandom_range(0, 2) == 0)
			app_scroll = pick_scroll();
		repeat (hops) begin
			if ($urandom_range(0, 9) < 8)
				pad = pad + int'($urandom_range(0, 4)) - 2;
			else
				pad = $urandom_range(0, 8);
			if (pad < 0)
				pad = 0;
			if (pad > 8)
				pad = 8;
			bits = 9'(1 << pad);
			if ($urandom_range(0, 3) == 0)
				bits = bits | (9'($urandom) & (9'h1FF << (pad + 1)));
			sim_ms = sim_ms + $urandom_range(0, 60);
			if ($urandom_range(0, 4) == 0)
				app_scroll = pick_scroll();
			push_poll(bits, sim_ms, app_scroll);
			if ($urandom_range(0, 7) == 0)
				push_poll(9'd0, sim_ms + $urandom_range(0, idle_timeout), app_scroll);
		end
		if ($urandom_range(0, 4) != 0) begin
			// idle poll just at the timeout must not release
			if ($urandom_range(0, 3) == 0)
				push_poll(9'd0, sim_ms + idle_timeout, app_scroll);
			sim_ms = sim_ms + idle_timeout + $urandom_range(1, 40);
			push_poll(9'd0, sim_ms, ($urandom_range(0, 1) != 0) ? app_scroll : pick_scroll());
		end
	endtask

	task noise_poll();
		push_poll(($urandom_range(0, 2) == 0) ? 9'd0 : 9'($urandom),
			($urandom_range(0, 1) != 0) ? $urandom : sim_ms + $urandom_range(0, 1000),
			16'($urandom));
	endtask

	initial begin
		int           chunk;
		int           start_count;
		logic [15:0]  cap_set[6];
		logic [7:0]   step_set[6];
		logic [15:0]  tmo_set[6];
		cap_set  = '{16'hFFFF, 16'd0,     16'd300, 16'd50, 16'hFFFF, 16'($urandom)};
		step_set = '{8'hFF,    8'd0,      8'd7,    8'd0,   8'd1,     8'($urandom_range(1, 255))};
		tmo_set  = '{16'd0,    16'hFFFF,  16'd40,  16'd10, 16'd100,  16'($urandom_range(0, 200))};

		// Known values on every input from the start
		poll_ch.valid = 1'b0;
		poll_ch.pad_bits = '0;
		poll_ch.now_ms = '0;
		poll_ch.current_scroll = '0;
		res_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MAX_SCROLL;
		cfg_data = '0;
		scroll_cap = 16'd0;
		step_lines = STEP_RESET;
		idle_timeout = TIMEOUT_RESET;
		held_pad = '0;
		touch_held = 1'b0;
		touch_stamp = '0;
		saved_scroll = '0;
		sim_ms = $urandom;
		app_scroll = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: register values after reset
		push_poll(9'd0, 32'd0, 16'd0);           // no touch while idle
		push_poll(9'h010, 32'd10, 16'd5);        // first touch, pad 4
		push_poll(9'h008, 32'd20, 16'd5);        // toward lower pads above the cap
		push_poll(9'h020, 32'd30, 16'd5);        // two pads up, subtract
		push_poll(9'd0, 32'd530, 16'd4);         // elapsed equals the timeout
		push_poll(9'd0, 32'd531, 16'd4);         // release with a changed scroll

		// Directed: large step, zero timeout, time counter wrap
		apply_settings(16'd1000, 8'hFF, 16'd0);
		push_poll(9'h1FF, 32'hFFFF_FFF0, 16'd999);
		push_poll(9'h100, 32'hFFFF_FFF2, 16'd999); // far jump latches only
		push_poll(9'h140, 32'hFFFF_FFF4, 16'd999); // add saturates at the cap
		push_poll(9'h040, 32'hFFFF_FFF6, 16'd1000); // same pad
		push_poll(9'h080, 32'hFFFF_FFF8, 16'd0);  // subtract from zero: no move
		push_poll(9'h100, 32'hFFFF_FFF8, 16'd100); // subtract clamps at zero
		push_poll(9'd0, 32'hFFFF_FFF8, 16'd0);   // no time passed
		push_poll(9'd0, 32'h0000_0005, 16'd0);   // elapsed across the wrap

		// Directed: zero step, full cap, longest timeout
		apply_settings(16'hFFFF, 8'd0, 16'hFFFF);
		push_poll(9'h004, 32'd0, 16'hFFFF);
		push_poll(9'h002, 32'd1, 16'hFFFF);      // scroll at the cap
		push_poll(9'h001, 32'd2, 16'd100);       // zero step still remembers
		push_poll(9'h004, 32'd3, 16'hFFFF);
		push_poll(9'd0, 32'd65538, 16'd12);      // elapsed equals the timeout
		push_poll(9'd0, 32'd65539, 16'd12);      // release
		push_poll(9'd0, 32'd200000, 16'd7);      // not tracking

		// Random chunks: three idling patterns, two settings each
		for (chunk = 0; chunk < 6; chunk++) begin
			apply_settings(cap_set[chunk], step_set[chunk], tmo_set[chunk]);
			case (chunk / 2)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 69;
				end
				1: begin
					send_idle_pct = 69;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			start_count = polls_queued;
			while (polls_queued - start_count < CHUNK_POLLS) begin
				if ($urandom_range(0, 4) != 0)
					slide_gesture();
				else
					noise_poll();
			end
			// long receiver stall with the sender still busy
			hold_req = ~hold_req;
		end

		wait_idle();
		repeat (6) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("** touch_slider_scroll_tracker_core: PASSED **");
		else
			$display("** touch_slider_scroll_tracker_core: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire
